FILE: rtl/source_text_token_scanner_macros.svh
// assertion macros for the token scanner
`ifndef SOURCE_TEXT_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TEXT_TOKEN_SCANNER_MACROS_SVH

// condition holds on every clock edge out of reset
`define SCN_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("token scanner check failed");

// antecedent implies consequent in the next cycle
`define SCN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token scanner check failed");

`endif

FILE: rtl/stscan_pkg.sv
// types, codes and helper functions of the token scanner
package stscan_pkg;

  localparam int unsigned MAX_SOURCE_BYTES = 65536;
  localparam int unsigned POS_CAP_INT =
    (MAX_SOURCE_BYTES - 1 < 65535) ? (MAX_SOURCE_BYTES - 1) : 65535;
  localparam logic [15:0] POS_CAP = POS_CAP_INT[15:0];

  localparam int unsigned MAX_TOKENS = 3;
  localparam int unsigned NUM_CAND = 5;

  // scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_BANG    = 4'd1;
  localparam logic [3:0] M_EQUAL   = 4'd2;
  localparam logic [3:0] M_GREATER = 4'd3;
  localparam logic [3:0] M_LESS    = 4'd4;
  localparam logic [3:0] M_SLASH   = 4'd5;
  localparam logic [3:0] M_COMMENT = 4'd6;
  localparam logic [3:0] M_STRING  = 4'd7;
  localparam logic [3:0] M_INT     = 4'd8;
  localparam logic [3:0] M_INT_DOT = 4'd9;
  localparam logic [3:0] M_FRAC    = 4'd10;
  localparam logic [3:0] M_IDENT   = 4'd11;

  // token kinds
  localparam logic [5:0] K_LPAREN    = 6'd0;
  localparam logic [5:0] K_RPAREN    = 6'd1;
  localparam logic [5:0] K_LBRACE    = 6'd2;
  localparam logic [5:0] K_RBRACE    = 6'd3;
  localparam logic [5:0] K_COMMA     = 6'd4;
  localparam logic [5:0] K_DOT       = 6'd5;
  localparam logic [5:0] K_MINUS     = 6'd6;
  localparam logic [5:0] K_PLUS      = 6'd7;
  localparam logic [5:0] K_SEMI      = 6'd8;
  localparam logic [5:0] K_SLASH     = 6'd9;
  localparam logic [5:0] K_STAR      = 6'd10;
  localparam logic [5:0] K_BANG      = 6'd11;
  localparam logic [5:0] K_BANG_EQ   = 6'd12;
  localparam logic [5:0] K_EQUAL     = 6'd13;
  localparam logic [5:0] K_EQUAL_EQ  = 6'd14;
  localparam logic [5:0] K_GREATER   = 6'd15;
  localparam logic [5:0] K_GREATER_EQ = 6'd16;
  localparam logic [5:0] K_LESS      = 6'd17;
  localparam logic [5:0] K_LESS_EQ   = 6'd18;
  localparam logic [5:0] K_IDENT     = 6'd19;
  localparam logic [5:0] K_STRING    = 6'd20;
  localparam logic [5:0] K_NUMBER    = 6'd21;
  localparam logic [5:0] K_AND       = 6'd22;
  localparam logic [5:0] K_FALSE     = 6'd23;
  localparam logic [5:0] K_IF        = 6'd24;
  localparam logic [5:0] K_OR        = 6'd25;
  localparam logic [5:0] K_PRINT     = 6'd26;
  localparam logic [5:0] K_RETURN    = 6'd27;
  localparam logic [5:0] K_TRUE      = 6'd28;
  localparam logic [5:0] K_VAR       = 6'd29;
  localparam logic [5:0] K_WHILE     = 6'd30;
  localparam logic [5:0] K_UNKNOWN   = 6'd31;
  localparam logic [5:0] K_UNTERM    = 6'd32;

  // keyword spellings, right aligned in the word register
  localparam logic [47:0] W_AND    = 48'h0000_0061_6e64;
  localparam logic [47:0] W_FALSE  = 48'h0066_616c_7365;
  localparam logic [47:0] W_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] W_OR     = 48'h0000_0000_6f72;
  localparam logic [47:0] W_PRINT  = 48'h0070_7269_6e74;
  localparam logic [47:0] W_RETURN = 48'h7265_7475_726e;
  localparam logic [47:0] W_TRUE   = 48'h0000_7472_7565;
  localparam logic [47:0] W_VAR    = 48'h0000_0076_6172;
  localparam logic [47:0] W_WHILE  = 48'h0077_6869_6c65;

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] length;
    logic [15:0] start;
    logic [5:0]  kind;
  } tok_t;

  typedef struct packed {
    tok_t t0;
    logic v0;
    tok_t t1;
    logic v1;
  } flush_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  function automatic tok_t tok_make(input logic [5:0] kind, input logic [15:0] start,
                                    input logic [16:0] end_pos, input logic [15:0] line);
    tok_t t;
    logic [16:0] len;
    len = (end_pos > {1'b0, start}) ? (end_pos - {1'b0, start}) : 17'd0;
    t.kind = kind;
    t.start = start;
    t.length = len[16] ? 16'hffff : len[15:0];
    t.line = line;
    return t;
  endfunction

  function automatic logic [5:0] op_kind(input logic [3:0] mode);
    logic [5:0] k;
    unique case (mode)
      M_BANG:    k = K_BANG;
      M_EQUAL:   k = K_EQUAL;
      M_GREATER: k = K_GREATER;
      default:   k = K_LESS;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] word_kind(input logic [47:0] word, input logic too_long);
    logic [5:0] k;
    unique case (word)
      W_AND:    k = K_AND;
      W_FALSE:  k = K_FALSE;
      W_IF:     k = K_IF;
      W_OR:     k = K_OR;
      W_PRINT:  k = K_PRINT;
      W_RETURN: k = K_RETURN;
      W_TRUE:   k = K_TRUE;
      W_VAR:    k = K_VAR;
      W_WHILE:  k = K_WHILE;
      default:  k = K_IDENT;
    endcase
    return too_long ? K_IDENT : k;
  endfunction

  // pending tokens of a mode, up to two, lexeme ending just before end_pos
  function automatic flush_t flush_tokens(input logic [3:0] mode, input logic [15:0] ls,
                                          input logic [16:0] end_pos,
                                          input logic [47:0] word, input logic too_long,
                                          input logic [15:0] line);
    flush_t f;
    logic [16:0] ls_end;
    logic [16:0] dot;
    ls_end = {1'b0, ls} + 17'd1;
    dot = (end_pos != 17'd0) ? (end_pos - 17'd1) : 17'd0;
    f.t0 = tok_make(K_SLASH, ls, ls_end, line);
    f.t1 = tok_make(K_DOT, dot[15:0], dot + 17'd1, line);
    f.v0 = 1'b0;
    f.v1 = 1'b0;
    unique case (mode)
      M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
        f.t0 = tok_make(op_kind(mode), ls, ls_end, line);
        f.v0 = 1'b1;
      end
      M_SLASH: f.v0 = 1'b1;
      M_STRING: begin
        f.t0 = tok_make(K_UNTERM, ls, end_pos, line);
        f.v0 = 1'b1;
      end
      M_INT, M_FRAC: begin
        f.t0 = tok_make(K_NUMBER, ls, end_pos, line);
        f.v0 = 1'b1;
      end
      M_INT_DOT: begin
        f.t0 = tok_make(K_NUMBER, ls, dot, line);
        f.v0 = 1'b1;
        f.v1 = 1'b1;
      end
      M_IDENT: begin
        f.t0 = tok_make(word_kind(word, too_long), ls, end_pos, line);
        f.v0 = 1'b1;
      end
      default: ;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/source_text_token_scanner.sv
// streaming lexical scanner: source bytes in, tokens out
//
//   channel | dir | tdata                  | tlast
//   in_     | in  | text_byte              | end_of_source
//   out_    | out | kind, start, len, line | last token of the byte
//
// one byte per cycle while each byte yields at most one token and out_tready is high
// a byte yielding two or three tokens holds in_tready low while the token queue drains
// tokens are registered: a token appears in the cycle after its byte is taken
// synchronous active-low reset returns to offset 0, line 1
// the final byte of a source also returns the scan state to reset values
module source_text_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [5:0] kind, [21:6] start, [37:22] length, [53:38] line
  output logic        out_tlast
);
  import stscan_pkg::*;

  logic [3:0]  mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] lstart_r, lstart_nxt;
  logic [15:0] line_r, line_nxt;
  logic [47:0] word_r, word_nxt;
  logic        long_r, long_nxt;

  tok_t        q_r [MAX_TOKENS];
  logic [2:0]  q_last_r;
  logic [1:0]  q_cnt_r;

  tok_t        slot [MAX_TOKENS];
  logic [2:0]  slot_last;
  logic [1:0]  slot_cnt;

  logic in_acc;
  logic out_pop;

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_pop = out_tvalid && out_tready;
  assign in_tready = (q_cnt_r == 2'd0) || ((q_cnt_r == 2'd1) && out_tready);
  assign in_acc = in_tvalid && in_tready;
  assign out_tdata = {2'b00, q_r[0]};
  assign out_tlast = q_last_r[0];

  always_comb begin
    logic [7:0]  c;
    logic [15:0] p;
    logic [16:0] p1;
    logic        used;
    logic [3:0]  mode_a;
    logic [15:0] line_a;
    logic [47:0] word_a;
    logic        long_a;
    logic [15:0] ls_b;
    flush_t      fa;
    flush_t      fc;
    tok_t        cand [NUM_CAND];
    logic [4:0]  cand_v;
    logic [1:0]  nv;

    c = in_tdata;
    p = pos_r;
    p1 = {1'b0, pos_r} + 17'd1;
    used = 1'b1;
    mode_a = mode_r;
    line_a = line_r;
    word_a = word_r;
    long_a = long_r;
    fa = flush_tokens(mode_r, lstart_r, {1'b0, p}, word_r, long_r, line_r);
    for (int i = 0; i < NUM_CAND; i++) begin
      cand[i] = fa.t0;
    end
    cand_v = '0;

    // continue the pending lexeme
    unique case (mode_r)
      M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
        if (c == "=") begin
          cand[0] = tok_make(op_kind(mode_r) + 6'd1, lstart_r, p1, line_r);
          cand_v[0] = 1'b1;
          mode_a = M_IDLE;
        end else begin
          used = 1'b0;
        end
      end
      M_SLASH: begin
        if (c == "/") mode_a = M_COMMENT;
        else used = 1'b0;
      end
      M_COMMENT: begin
        if (c == 8'h0a) begin
          mode_a = M_IDLE;
          if (line_r != 16'hffff) line_a = line_r + 16'd1;
        end
      end
      M_STRING: begin
        if (c == 8'h22) begin
          cand[0] = tok_make(K_STRING, lstart_r, p1, line_r);
          cand_v[0] = 1'b1;
          mode_a = M_IDLE;
        end else if (c == 8'h0a) begin
          if (line_r != 16'hffff) line_a = line_r + 16'd1;
        end
      end
      M_INT: begin
        if (c == ".") mode_a = M_INT_DOT;
        else if (!is_digit(c)) used = 1'b0;
      end
      M_INT_DOT: begin
        if (is_digit(c)) mode_a = M_FRAC;
        else used = 1'b0;
      end
      M_FRAC: begin
        if (!is_digit(c)) used = 1'b0;
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (word_r[47:40] != 8'h00) long_a = 1'b1;
          word_a = {word_r[39:0], c};
        end else begin
          used = 1'b0;
        end
      end
      default: begin
        used = 1'b0;
      end
    endcase

    // flush of the pending lexeme when the byte ends it
    if (!used && (mode_r != M_IDLE)) begin
      cand[0] = fa.t0;
      cand_v[0] = fa.v0;
      cand[1] = fa.t1;
      cand_v[1] = fa.v1;
    end

    // byte starts a new lexeme
    ls_b = lstart_r;
    if (!used) begin
      ls_b = p;
      mode_a = M_IDLE;
      cand[2] = tok_make(K_UNKNOWN, p, p1, line_r);
      unique case (c)
        8'h20, 8'h0d, 8'h09: ;
        8'h0a: if (line_r != 16'hffff) line_a = line_r + 16'd1;
        "(": begin cand[2].kind = K_LPAREN; cand_v[2] = 1'b1; end
        ")": begin cand[2].kind = K_RPAREN; cand_v[2] = 1'b1; end
        "{": begin cand[2].kind = K_LBRACE; cand_v[2] = 1'b1; end
        "}": begin cand[2].kind = K_RBRACE; cand_v[2] = 1'b1; end
        ",": begin cand[2].kind = K_COMMA;  cand_v[2] = 1'b1; end
        ".": begin cand[2].kind = K_DOT;    cand_v[2] = 1'b1; end
        "-": begin cand[2].kind = K_MINUS;  cand_v[2] = 1'b1; end
        "+": begin cand[2].kind = K_PLUS;   cand_v[2] = 1'b1; end
        ";": begin cand[2].kind = K_SEMI;   cand_v[2] = 1'b1; end
        "*": begin cand[2].kind = K_STAR;   cand_v[2] = 1'b1; end
        "!": mode_a = M_BANG;
        "=": mode_a = M_EQUAL;
        ">": mode_a = M_GREATER;
        "<": mode_a = M_LESS;
        "/": mode_a = M_SLASH;
        8'h22: mode_a = M_STRING;
        default: begin
          if (is_digit(c)) begin
            mode_a = M_INT;
          end else if (is_alpha(c)) begin
            mode_a = M_IDENT;
            word_a = {40'h0, c};
            long_a = 1'b0;
          end else begin
            cand_v[2] = 1'b1;
          end
        end
      endcase
    end

    // end of source flushes whatever is pending
    fc = flush_tokens(mode_a, ls_b, p1, word_a, long_a, line_a);
    cand[3] = fc.t0;
    cand[4] = fc.t1;
    cand_v[3] = in_tlast && fc.v0;
    cand_v[4] = in_tlast && fc.v1;

    if (in_tlast) begin
      mode_nxt = M_IDLE;
      pos_nxt = 16'd0;
      lstart_nxt = 16'd0;
      line_nxt = 16'd1;
      word_nxt = 48'h0;
      long_nxt = 1'b0;
    end else begin
      mode_nxt = mode_a;
      pos_nxt = (pos_r < POS_CAP) ? (pos_r + 16'd1) : pos_r;
      lstart_nxt = ls_b;
      line_nxt = line_a;
      word_nxt = word_a;
      long_nxt = long_a;
    end

    // pack the valid tokens into the queue slots in order
    for (int j = 0; j < MAX_TOKENS; j++) begin
      slot[j] = cand[j];
    end
    nv = 2'd0;
    for (int i = 0; i < NUM_CAND; i++) begin
      if (cand_v[i] && (nv != 2'd3)) begin
        slot[nv] = cand[i];
        nv = nv + 2'd1;
      end
    end
    slot_cnt = nv;
    for (int j = 0; j < MAX_TOKENS; j++) begin
      slot_last[j] = (nv != 2'd0) && (j[1:0] == (nv - 2'd1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r <= 16'd0;
      lstart_r <= 16'd0;
      line_r <= 16'd1;
      word_r <= 48'h0;
      long_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        pos_r <= pos_nxt;
        lstart_r <= lstart_nxt;
        line_r <= line_nxt;
        word_r <= word_nxt;
        long_r <= long_nxt;
        q_cnt_r <= slot_cnt;
      end else if (out_pop) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int j = 0; j < MAX_TOKENS; j++) begin
        q_r[j] <= slot[j];
      end
      q_last_r <= slot_last;
    end else if (out_pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
      q_last_r <= {1'b0, q_last_r[2:1]};
    end
  end

`include "source_text_token_scanner_macros.svh"

  `SCN_ASSERT_ALWAYS(a_line_nonzero, line_r != 16'd0)
  `SCN_ASSERT_ALWAYS(a_last_only_at_tail, (q_cnt_r > 2'd1) |-> !q_last_r[0])
  `SCN_ASSERT_NEXT(a_source_end_resets, in_acc && in_tlast,
                   (pos_r == 16'd0) && (mode_r == M_IDLE) && (line_r == 16'd1))

endmodule
